/* src/spg_pkg.sv */
package spg_pkg;

  // Operation codes carried by the operation field.
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_ATTACH = 2'd2;
  localparam logic [1:0] OP_DETACH = 2'd3;

  // Default parameter values.
  localparam int CLOCK_MHZ_DEF  = 16;
  localparam int REFRESH_US_DEF = 20000;
  localparam int MIN_US_DEF     = 544;
  localparam int MAX_US_DEF     = 2400;
  localparam int TRIM_TICKS_DEF = 2;

  // Fixed constants of the pulse arithmetic.
  localparam int DEFAULT_US     = 1500;
  localparam int PRESCALE       = 8;
  localparam int PRESCALE_SHIFT = 3;
  localparam int MAX_DEGREES    = 180;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int VALUE_W = 16;
  localparam int US_W    = 12;
  localparam int TICKS_W = 16;
  localparam int DEG_W   = 8;

  // Angle to microseconds lookup, one entry per whole degree.
  localparam int ANGLE_ENTRIES = 256;
  typedef logic [US_W-1:0] angle_table_t [ANGLE_ENTRIES];

  // Load strobes for the two readback stages.
  typedef struct packed {
    logic load_rb;
    logic load_out;
  } rb_ctrl_t;

  function automatic angle_table_t build_angle_table(input int min_us, input int max_us);
    angle_table_t t;
    for (int i = 0; i < ANGLE_ENTRIES; i++) begin
      if (i <= MAX_DEGREES) begin
        t[i] = US_W'(i * (max_us - min_us) / MAX_DEGREES + min_us);
      end else begin
        t[i] = US_W'(max_us);
      end
    end
    return t;
  endfunction

endpackage

/* src/spg_pulse_core.sv */
module spg_pulse_core
  import spg_pkg::*;
#(
  parameter int CLOCK_MHZ  = CLOCK_MHZ_DEF,
  parameter int REFRESH_US = REFRESH_US_DEF,
  parameter int MIN_US     = MIN_US_DEF,
  parameter int MAX_US     = MAX_US_DEF,
  parameter int TRIM_TICKS = TRIM_TICKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [OP_W-1:0]           operation,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      pin_level,
  output logic                      attached,
  output logic [TICKS_W-1:0]        pulse_ticks
);

  localparam angle_table_t AngleTable = build_angle_table(MIN_US, MAX_US);

  localparam logic [TICKS_W-1:0] TrimTicks = TICKS_W'(TRIM_TICKS);
  localparam logic [TICKS_W-1:0] RefreshTicks = TICKS_W'((CLOCK_MHZ * REFRESH_US) / PRESCALE);
  localparam logic [TICKS_W-1:0] RefreshMatch = RefreshTicks - TrimTicks;
  localparam logic [TICKS_W-1:0] DefaultTicks = TICKS_W'((CLOCK_MHZ * DEFAULT_US) / PRESCALE);
  localparam logic signed [VALUE_W-1:0] MinUsS = VALUE_W'(MIN_US);
  localparam logic signed [VALUE_W-1:0] MaxUsS = VALUE_W'(MAX_US);
  localparam logic signed [VALUE_W-1:0] MaxDegS = VALUE_W'(MAX_DEGREES);
  localparam int ProdW = US_W + 6;

  logic                 high_phase, high_phase_next;
  logic [TICKS_W-1:0]   frame_count, frame_count_next;
  logic [TICKS_W-1:0]   match_point, match_point_next;
  logic                 pin_level_next, attached_next;
  logic [TICKS_W-1:0]   pulse_ticks_next;

  logic [DEG_W-1:0]     deg_idx;
  logic [US_W-1:0]      write_us;
  logic [ProdW-1:0]     write_prod;
  logic [TICKS_W-1:0]   write_ticks;

  // Position write: an angle goes through the lookup, a time is clamped.
  always_comb begin
    if (value[VALUE_W-1]) begin
      deg_idx = '0;
    end else if (value > MaxDegS) begin
      deg_idx = DEG_W'(MAX_DEGREES);
    end else begin
      deg_idx = value[DEG_W-1:0];
    end
    if (value < MinUsS) begin
      write_us = AngleTable[deg_idx];
    end else if (value > MaxUsS) begin
      write_us = US_W'(MAX_US);
    end else begin
      write_us = value[US_W-1:0];
    end
    write_prod  = ProdW'(CLOCK_MHZ) * ProdW'(write_us - US_W'(TRIM_TICKS));
    write_ticks = TICKS_W'(write_prod >> PRESCALE_SHIFT);
  end

  always_comb begin
    pin_level_next   = pin_level;
    attached_next    = attached;
    pulse_ticks_next = pulse_ticks;
    high_phase_next  = high_phase;
    frame_count_next = frame_count;
    match_point_next = match_point;
    unique case (operation)
      OP_TICK: begin
        if (attached) begin
          if (frame_count == match_point) begin
            if (!high_phase) begin
              pin_level_next   = 1'b1;
              frame_count_next = '0;
              match_point_next = pulse_ticks - TrimTicks;
              high_phase_next  = 1'b1;
            end else begin
              pin_level_next   = 1'b0;
              match_point_next = RefreshMatch;
              high_phase_next  = 1'b0;
              frame_count_next = frame_count + 1'b1;
            end
          end else begin
            frame_count_next = frame_count + 1'b1;
          end
        end
      end
      OP_WRITE: begin
        pulse_ticks_next = write_ticks;
      end
      OP_ATTACH: begin
        if (!attached) begin
          pulse_ticks_next = DefaultTicks;
          high_phase_next  = 1'b0;
          frame_count_next = '0;
          match_point_next = '0;
          attached_next    = 1'b1;
        end
      end
      OP_DETACH: begin
        attached_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_level   <= 1'b0;
      attached    <= 1'b0;
      pulse_ticks <= '0;
      high_phase  <= 1'b0;
      frame_count <= '0;
      match_point <= '0;
    end else if (load) begin
      pin_level   <= pin_level_next;
      attached    <= attached_next;
      pulse_ticks <= pulse_ticks_next;
      high_phase  <= high_phase_next;
      frame_count <= frame_count_next;
      match_point <= match_point_next;
    end
  end

endmodule

/* src/spg_readback.sv */
module spg_readback
  import spg_pkg::*;
#(
  parameter int CLOCK_MHZ  = CLOCK_MHZ_DEF,
  parameter int MIN_US     = MIN_US_DEF,
  parameter int MAX_US     = MAX_US_DEF,
  parameter int TRIM_TICKS = TRIM_TICKS_DEF
) (
  input  logic                clk,
  input  rb_ctrl_t            ctrl,
  input  logic                pin_in,
  input  logic                active_in,
  input  logic [TICKS_W-1:0]  pulse_ticks,
  output logic                pin_level,
  output logic                active,
  output logic [US_W-1:0]     readback_us,
  output logic [DEG_W-1:0]    readback_degrees
);

  // Division by the clock rate and by the span is a multiply by a rounded-up
  // reciprocal; the shifts are wide enough that the floor is exact for every
  // reachable operand.
  localparam int RbShift  = 25;
  localparam int RbRecipW = 23;
  localparam logic [RbRecipW-1:0] RbRecip =
    RbRecipW'(((longint'(1) << RbShift) + CLOCK_MHZ - 1) / CLOCK_MHZ);
  localparam int RbNumW  = TICKS_W + PRESCALE_SHIFT;
  localparam int RbProdW = RbNumW + RbRecipW;

  localparam int DegShift  = 24;
  localparam int DegRecipW = 23;
  localparam longint SpanUs = longint'(MAX_US - MIN_US);
  localparam logic [DegRecipW-1:0] DegRecip =
    DegRecipW'(((longint'(MAX_DEGREES) << DegShift) + SpanUs - 1) / SpanUs);
  localparam int DegProdW = US_W + DegRecipW;
  localparam int DegQW    = DegProdW - DegShift;

  logic                rb_pin, rb_active;
  logic [US_W-1:0]     rb_us;
  logic [RbProdW-1:0]  rb_prod;
  logic [US_W-1:0]     rb_us_next;

  logic [US_W:0]       num;
  logic [US_W-1:0]     diff;
  logic [DegProdW-1:0] deg_prod;
  logic [DegQW-1:0]    deg_q;
  logic [DEG_W-1:0]    deg_next;

  always_comb begin
    rb_prod    = RbProdW'({pulse_ticks, {PRESCALE_SHIFT{1'b0}}}) * RbProdW'(RbRecip);
    rb_us_next = US_W'(rb_prod >> RbShift) + US_W'(TRIM_TICKS);
  end

  always_comb begin
    num      = {1'b0, rb_us} + 1'b1;
    diff     = US_W'(num - (US_W + 1)'(MIN_US));
    deg_prod = DegProdW'(diff) * DegProdW'(DegRecip);
    deg_q    = DegQW'(deg_prod >> DegShift);
    if (num <= (US_W + 1)'(MIN_US)) begin
      deg_next = '0;
    end else if (deg_q > DegQW'(MAX_DEGREES)) begin
      deg_next = DEG_W'(MAX_DEGREES);
    end else begin
      deg_next = deg_q[DEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_rb) begin
      rb_pin    <= pin_in;
      rb_active <= active_in;
      rb_us     <= rb_us_next;
    end
    if (ctrl.load_out) begin
      pin_level        <= rb_pin;
      active           <= rb_active;
      readback_us      <= rb_us;
      readback_degrees <= deg_next;
    end
  end

endmodule

/* src/servo_pulse_generator_top.sv */
// An accepted word reaches the output after the servo state and microsecond readback
// stages. Throughput: one word per cycle while the output is not stalled; the state
// update and the two readbacks each take one register stage, so nothing loops back.
// Reset (rst, synchronous, active high) detaches the servo, drives the pin low, clears
// the stored pulse, the frame counter and the pipeline valid flags.
module servo_pulse_generator_top
  import spg_pkg::*;
#(
  parameter int CLOCK_MHZ  = CLOCK_MHZ_DEF,
  parameter int REFRESH_US = REFRESH_US_DEF,
  parameter int MIN_US     = MIN_US_DEF,
  parameter int MAX_US     = MAX_US_DEF,
  parameter int TRIM_TICKS = TRIM_TICKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           operation,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      pin_level,
  output logic                      active,
  output logic [US_W-1:0]           readback_us,
  output logic [DEG_W-1:0]          readback_degrees
);

  // The pipeline has four places a word can sit:
  //   stage 0 holds the accepted word (operation and value),
  //   stage 1 is the servo state itself, right after the word was applied,
  //   stage 2 holds the readback in microseconds,
  //   stage 3 is the output register with the readback in degrees.
  // Each stage takes a new word when it is empty or when its own word moves on, so
  // bubbles close up and the input flows while a result waits, until all stages fill.
  logic                     valid0, valid1, valid2;
  logic [OP_W-1:0]          op0;
  logic signed [VALUE_W-1:0] value0;

  logic ready0, ready1, ready2, ready3;
  logic move01, move12, move23;

  logic                 core_pin, core_attached;
  logic [TICKS_W-1:0]   core_ticks;
  rb_ctrl_t             rb_ctrl;

  assign ready3 = !out_valid || !out_stall;
  assign ready2 = !valid2 || ready3;
  assign ready1 = !valid1 || ready2;
  assign ready0 = !valid0 || ready1;

  assign move01 = valid0 && ready1;
  assign move12 = valid1 && ready2;
  assign move23 = valid2 && ready3;

  assign in_stall = !ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0    <= 1'b0;
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid0    <= (in_valid && ready0) || (valid0 && !ready1);
      valid1    <= move01 || (valid1 && !ready2);
      valid2    <= move12 || (valid2 && !ready3);
      out_valid <= move23 || (out_valid && out_stall);
    end
  end

  // The input register only loads when the stage is free, so a held word stays put.
  // The operation starts out as a tick so the state decoder always sees a known code.
  always_ff @(posedge clk) begin
    if (rst) begin
      op0 <= OP_TICK;
    end else if (in_valid && ready0) begin
      op0    <= operation;
      value0 <= value;
    end
  end

  // The servo state is written only when stage 1 is free, which keeps the state
  // registers equal to the stage 1 word for as long as that word waits.
  spg_pulse_core #(
    .CLOCK_MHZ  (CLOCK_MHZ),
    .REFRESH_US (REFRESH_US),
    .MIN_US     (MIN_US),
    .MAX_US     (MAX_US),
    .TRIM_TICKS (TRIM_TICKS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .load        (move01),
    .operation   (op0),
    .value       (value0),
    .pin_level   (core_pin),
    .attached    (core_attached),
    .pulse_ticks (core_ticks)
  );

  assign rb_ctrl = '{load_rb: move12, load_out: move23};

  spg_readback #(
    .CLOCK_MHZ  (CLOCK_MHZ),
    .MIN_US     (MIN_US),
    .MAX_US     (MAX_US),
    .TRIM_TICKS (TRIM_TICKS)
  ) u_readback (
    .clk              (clk),
    .ctrl             (rb_ctrl),
    .pin_in           (core_pin),
    .active_in        (core_attached),
    .pulse_ticks      (core_ticks),
    .pin_level        (pin_level),
    .active           (active),
    .readback_us      (readback_us),
    .readback_degrees (readback_degrees)
  );

  // With the output register empty every stage can move, so the input never stalls.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register was empty");

  // A detached servo keeps its pin frozen.
  a_pin_frozen_detached: assert property (@(posedge clk) disable iff (rst)
    !core_attached |=> $stable(core_pin))
    else $error("pin changed while detached");

  // Attaching from the detached state always leaves the servo attached.
  a_attach_takes: assert property (@(posedge clk) disable iff (rst)
    (move01 && op0 == OP_ATTACH) |=> core_attached)
    else $error("attach did not take effect");

  // The servo state only changes when a word is applied to it.
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !move01 |=> ($stable(core_ticks) && $stable(core_attached)))
    else $error("servo state changed without a word");

endmodule

/* dv/tb_servo_pulse_generator_top.sv */
module tb_servo_pulse_generator_top;
  import spg_pkg::*;

  // The block runs with its default parameters, so the predictor uses the same values.
  localparam int CLK_MHZ     = CLOCK_MHZ_DEF;
  localparam int REFRESH     = REFRESH_US_DEF;
  localparam int PULSE_MIN   = MIN_US_DEF;
  localparam int PULSE_MAX   = MAX_US_DEF;
  localparam int TRIM        = TRIM_TICKS_DEF;

  // The frame period in ticks, kept to sixteen bits as the block keeps it.
  localparam logic [TICKS_W-1:0] REFRESH_TICKS = TICKS_W'(CLK_MHZ * REFRESH / PRESCALE);

  localparam int RANDOM_WORDS   = 700;
  localparam int HOLD_CYCLES    = 200;
  localparam int PRESSURE_WORDS = 64;
  // Cycles to keep watching the output after the last predicted word has been seen.
  localparam int DRAIN_CYCLES   = 12;
  // The slowest correct run is far below this: about 2000 words, each waiting out at
  // most the longest sender gap and a few long receiver stalls, plus one long hold.
  localparam longint LIMIT_CYCLES = 2_000_000;

  // One result word as the block reports it.
  typedef struct packed {
    logic              pin;
    logic              attached;
    logic [US_W-1:0]   us;
    logic [DEG_W-1:0]  degrees;
  } servo_status_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OP_W-1:0]           operation = OP_TICK;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      pin_level;
  logic                      active;
  logic [US_W-1:0]           readback_us;
  logic [DEG_W-1:0]          readback_degrees;

  // Predicted servo state, updated once for every accepted word.
  logic                      srv_attached = 1'b0;
  logic [TICKS_W-1:0]        srv_pulse_ticks = '0;
  logic                      srv_high_phase = 1'b0;
  logic [TICKS_W-1:0]        srv_frame_count = '0;
  logic [TICKS_W-1:0]        srv_match_point = '0;
  logic                      srv_pin = 1'b0;

  // Status words predicted but not yet seen at the output, oldest first.
  servo_status_t             pending_status[$];

  int  words_sent = 0;
  int  results_checked = 0;
  int  mismatches = 0;
  int  pin_rises = 0;
  logic last_pin = 1'b0;

  // Idling controls shared by the test tasks and the receiver process.
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_request = 1'b0;

  servo_pulse_generator_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .value            (value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pin_level        (pin_level),
    .active           (active),
    .readback_us      (readback_us),
    .readback_degrees (readback_degrees)
  );

  // A 20-unit clock period: ten units low, ten units high.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap lengths: mostly a few cycles, now and then a long pause.
  function automatic int pick_gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(15, 50);
    end
    return $urandom_range(1, 4);
  endfunction

  // The sender idles after half of its words when idling is enabled.
  function automatic int pick_tx_gap();
    if (!tx_idle_on || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return pick_gap_len();
  endfunction

  // Position values: the full sixteen-bit range, plausible angles, plausible pulse
  // widths and the exact clamp boundaries, in roughly equal shares.
  function automatic logic signed [VALUE_W-1:0] pick_position();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        return VALUE_W'($urandom);
      end
      1: begin
        return VALUE_W'($urandom_range(0, 200));
      end
      2: begin
        return VALUE_W'($urandom_range(PULSE_MIN - 50, PULSE_MAX + 100));
      end
      default: begin
        case ($urandom_range(0, 5))
          0: return VALUE_W'(PULSE_MIN - 1);
          1: return VALUE_W'(PULSE_MIN);
          2: return VALUE_W'(PULSE_MAX);
          3: return VALUE_W'(PULSE_MAX + 1);
          4: return VALUE_W'(MAX_DEGREES);
          default: return VALUE_W'(-1);
        endcase
      end
    endcase
  endfunction

  // Advances the predicted state by one word and queues the status it must produce.
  task automatic predict_status(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
    int pulse_us;
    int angle;
    int rb_us;
    int num;
    int deg;
    servo_status_t status;
    case (op)
      OP_TICK: begin
        if (srv_attached) begin
          if (srv_frame_count == srv_match_point) begin
            if (!srv_high_phase) begin
              // Frame start: the pin rises and the counter times the pulse.
              srv_pin = 1'b1;
              srv_frame_count = '0;
              srv_match_point = srv_pulse_ticks - TICKS_W'(TRIM);
              srv_high_phase = 1'b1;
            end else begin
              // End of the pulse: the pin falls and the counter runs to frame end.
              srv_pin = 1'b0;
              srv_match_point = REFRESH_TICKS - TICKS_W'(TRIM);
              srv_high_phase = 1'b0;
              srv_frame_count = srv_frame_count + 1'b1;
            end
          end else begin
            srv_frame_count = srv_frame_count + 1'b1;
          end
        end
      end
      OP_WRITE: begin
        pulse_us = v;
        if (pulse_us < PULSE_MIN) begin
          // Small values are angles in degrees.
          angle = v;
          if (angle < 0) begin
            angle = 0;
          end else if (angle > MAX_DEGREES) begin
            angle = MAX_DEGREES;
          end
          pulse_us = angle * (PULSE_MAX - PULSE_MIN) / MAX_DEGREES + PULSE_MIN;
        end
        if (pulse_us < PULSE_MIN) begin
          pulse_us = PULSE_MIN;
        end else if (pulse_us > PULSE_MAX) begin
          pulse_us = PULSE_MAX;
        end
        pulse_us = pulse_us - TRIM;
        if (pulse_us < 0) begin
          pulse_us = 0;
        end
        srv_pulse_ticks = TICKS_W'(CLK_MHZ * pulse_us / PRESCALE);
      end
      OP_ATTACH: begin
        if (!srv_attached) begin
          srv_pulse_ticks = TICKS_W'(CLK_MHZ * DEFAULT_US / PRESCALE);
          srv_high_phase = 1'b0;
          srv_frame_count = '0;
          srv_match_point = '0;
          srv_attached = 1'b1;
        end
      end
      default: begin
        srv_attached = 1'b0;
      end
    endcase

    rb_us = int'(srv_pulse_ticks) * PRESCALE / CLK_MHZ + TRIM;
    num = rb_us + 1;
    if (num <= PULSE_MIN) begin
      deg = 0;
    end else begin
      deg = (num - PULSE_MIN) * MAX_DEGREES / (PULSE_MAX - PULSE_MIN);
      if (deg > MAX_DEGREES) begin
        deg = MAX_DEGREES;
      end
    end
    status.pin = srv_pin;
    status.attached = srv_attached;
    status.us = US_W'(rb_us);
    status.degrees = DEG_W'(deg);
    pending_status.push_back(status);
  endtask

  // Offers one word, waits until the block takes it, then idles for a random gap.
  // Handshake signals are sampled at the rising edge, before the block updates them.
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    operation <= op;
    value <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_status(op, v);
    words_sent++;
    gap = pick_tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Ticks carry a random value, which the block must ignore.
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(OP_TICK, VALUE_W'($urandom));
    end
  endtask

  // Right after reset: nothing is attached and the readback shows only the trim.
  task automatic test_idle_readback();
    send_word(OP_TICK, '0);
    send_word(OP_DETACH, VALUE_W'(16'h7FFF));
    send_word(OP_TICK, VALUE_W'(16'h8000));
  endtask

  // Position writes at every clamp boundary and the extremes of the signed range.
  task automatic test_position_writes();
    logic signed [VALUE_W-1:0] positions[16];
    positions = '{VALUE_W'(-32768), VALUE_W'(-1), VALUE_W'(0), VALUE_W'(1),
                  VALUE_W'(90), VALUE_W'(179), VALUE_W'(180), VALUE_W'(181),
                  VALUE_W'(543), VALUE_W'(544), VALUE_W'(545), VALUE_W'(1500),
                  VALUE_W'(2399), VALUE_W'(2400), VALUE_W'(2401), VALUE_W'(32767)};
    foreach (positions[i]) begin
      send_word(OP_WRITE, positions[i]);
    end
  endtask

  // Attach loads the default pulse once; a second attach must not reload it, and a
  // write while detached still changes the stored pulse.
  task automatic test_attach_detach();
    send_word(OP_ATTACH, VALUE_W'(16'h5555));
    send_word(OP_WRITE, VALUE_W'(90));
    send_word(OP_ATTACH, VALUE_W'(16'hAAAA));
    send_ticks(2);
    send_word(OP_DETACH, '0);
    send_word(OP_WRITE, VALUE_W'(PULSE_MAX));
    send_word(OP_TICK, '0);
    send_word(OP_ATTACH, '0);
    send_word(OP_DETACH, '0);
  endtask

  // Frame start and pulse end: the shortest pulse written before the first tick, a
  // detach with the pin frozen high, and a reattach that reloads the default pulse and
  // restarts the frame; the shortest pulse is then written again and runs to its end.
  task automatic test_frame_timing();
    send_word(OP_ATTACH, '0);
    send_word(OP_WRITE, VALUE_W'(PULSE_MIN));
    tx_idle_on = 1'b0;
    send_ticks(100);
    send_word(OP_DETACH, '0);
    tx_idle_on = 1'b1;
    send_ticks(20);
    send_word(OP_ATTACH, '0);
    send_word(OP_WRITE, VALUE_W'(PULSE_MIN));
    tx_idle_on = 1'b0;
    send_ticks(1000);
    tx_idle_on = 1'b1;
    send_ticks(100);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < PRESSURE_WORDS; i++) begin
      if (i % 8 == 3) begin
        send_word(OP_WRITE, pick_position());
      end else begin
        send_word(OP_TICK, VALUE_W'($urandom));
      end
    end
    tx_idle_on = 1'b1;
  endtask

  // Random traffic: mostly attached runs of ticks with writes mixed in, and some noise
  // of arbitrary operations, detaches and repeated attaches.
  task automatic test_random_traffic();
    int goal;
    int run_len;
    logic [OP_W-1:0] op;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        send_word(OP_ATTACH, VALUE_W'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          send_word(OP_WRITE, pick_position());
        end
        run_len = $urandom_range(10, 80);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_word(OP_WRITE, pick_position());
          end else begin
            send_word(OP_TICK, VALUE_W'($urandom));
          end
        end
      end else begin
        run_len = $urandom_range(3, 20);
        for (int i = 0; i < run_len; i++) begin
          op = OP_W'($urandom_range(0, 3));
          if (op == OP_WRITE) begin
            send_word(op, pick_position());
          end else begin
            send_word(op, VALUE_W'($urandom));
          end
        end
      end
      // Toggle the idling now and then so some stretches run back to back.
      if ($urandom_range(0, 7) == 0) begin
        tx_idle_on = !tx_idle_on;
      end
      if ($urandom_range(0, 7) == 0) begin
        rx_idle_on = !rx_idle_on;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver: random stalls of mostly short length, plus the long counted hold-off.
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap_len();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Result checker: every accepted status word is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    servo_status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected status word: pin=%0b active=%0b us=%0d deg=%0d",
                   pin_level, active, readback_us, readback_degrees);
        end
      end else begin
        want = pending_status.pop_front();
        results_checked++;
        if (pin_level !== want.pin || active !== want.attached ||
            readback_us !== want.us || readback_degrees !== want.degrees) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("status word %0d mismatch: expected pin=%0b active=%0b us=%0d deg=%0d,",
                     results_checked, want.pin, want.attached, want.us, want.degrees);
            $display("  got pin=%0b active=%0b us=%0d deg=%0d",
                     pin_level, active, readback_us, readback_degrees);
          end
        end
        if (pin_level === 1'b1 && last_pin === 1'b0) begin
          pin_rises++;
        end
        last_pin = pin_level;
      end
    end
  end

  // Main sequence: one reset, then each test in turn, then drain and report.
  initial begin : main_sequence
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_readback();
    test_position_writes();
    test_attach_detach();
    test_frame_timing();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) begin
      @(posedge clk);
    end
    // Anything the block offers during this drain would have no prediction waiting.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Summary: %0d words sent, %0d status words checked, %0d rising pin edges seen.",
             words_sent, results_checked, pin_rises);
    $display("Covered clamped position writes, attach and detach, pulse start and end,");
    $display("and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    #(LIMIT_CYCLES * 20);
    $display("Timeout with %0d status words still expected.", pending_status.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/spg_pkg.sv
src/spg_pulse_core.sv
src/spg_readback.sv
src/servo_pulse_generator_top.sv
dv/tb_servo_pulse_generator_top.sv
